@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the hash table block.
// No dependencies; define SYNTH to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, prop, msg)
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`endif

`endif

@@ rtl/core/chtd_pkg.sv @@
// Types and constants of the clustered hash table block.
// No dependencies; used by the way evaluator and the top level.
package chtd_pkg;

  localparam int TAG_W   = 16;
  localparam int COUNT_W = 13;
  localparam int GEN_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
  localparam int unsigned        AGE_MARGIN = 3;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SAVE   = 1'b1;

  typedef enum logic [2:0] {
    STAT_MISS     = 3'd0,
    STAT_HIT      = 3'd1,
    STAT_STORED   = 3'd2,
    STAT_REPLACED = 3'd3,
    STAT_DROPPED  = 3'd4
  } status_e;

  // One way of a cluster as kept in the table memory.
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic signed [15:0] eval;
    logic [7:0]         depth;
    logic [1:0]         flag;
    logic [15:0]        move;
    logic [GEN_W-1:0]   gen;
  } way_entry_t;

  // Verdict of the shared compare unit on one way.
  typedef struct packed {
    logic empty;
    logic hit;
    logic old;
  } way_eval_t;

endpackage

@@ rtl/core/chtd_if.sv @@
// Valid/ready channel interfaces of the clustered hash table block.
// No dependencies; field widths are written as literals.
interface chtd_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic [63:0]        key;
  logic signed [15:0] entry_eval;
  logic [7:0]         entry_depth;
  logic [1:0]         entry_flag;
  logic [15:0]        entry_move;
  logic [7:0]         entry_generation;

  modport source (output valid, command, key, entry_eval, entry_depth, entry_flag,
                  entry_move, entry_generation, input ready);
  modport sink (input valid, command, key, entry_eval, entry_depth, entry_flag,
                entry_move, entry_generation, output ready);
endinterface

interface chtd_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] found_eval;
  logic [7:0]         found_depth;
  logic [1:0]         found_flag;
  logic [15:0]        found_move;
  logic [12:0]        entry_count;

  modport source (output valid, status, found_eval, found_depth, found_flag, found_move,
                  entry_count, input ready);
  modport sink (input valid, status, found_eval, found_depth, found_flag, found_move,
                entry_count, output ready);
endinterface

interface chtd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/core/clustered_hash_table_with_depth_replace_unit.sv @@
// Top level of the clustered hash table with depth and age replacement.
// Depends on chtd_pkg, chtd_if, chtd_way_eval and assert_macros.svh.
//
// Set-associative table of 2**INDEX_BITS clusters of WAYS ways, held in one
// memory with a registered read port and a separate write port. After reset
// the block sweeps the memory once to clear the valid bits, one entry per
// cycle over all 2**(INDEX_BITS + WayBits) entries (4096 by default); no
// request word is taken meanwhile, configuration writes are. Each request
// word then scans from 1 to WAYS ways and is finished before the next
// request word is accepted: the memory read port delivers one way per
// cycle to a single compare unit, and a lookup hit or, for a save, an
// empty way ends the scan early. A result waits in an output register;
// the block only stalls at the end of a scan while the previous result
// has not been taken.
module clustered_hash_table_with_depth_replace_unit #(
  parameter int INDEX_BITS = 10,
  parameter int WAYS       = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chtd_req_if.sink   req_i,
  chtd_rsp_if.source rsp_o,
  chtd_cfg_if.sink   cfg_i
);
  import chtd_pkg::*;

  `include "assert_macros.svh"

  localparam int WayBits  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AddrBits = INDEX_BITS + WayBits;
  localparam int Depth    = 1 << AddrBits;
  localparam logic [WayBits-1:0]  LastWay = WayBits'(WAYS - 1);
  localparam logic [AddrBits-1:0] LastAddr = {AddrBits{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [AddrBits-1:0]    clr_q;
  logic [GEN_W-1:0]       cur_gen_q;
  logic [WayBits-1:0]     way_q;
  logic [WayBits-1:0]     wr_way_q;
  logic [WayBits-1:0]     cand_way_q;
  logic                   cand_q;
  logic                   do_write_q;
  logic [INDEX_BITS-1:0]  cluster_q;
  logic                   save_q;
  logic [TAG_W-1:0]       tag_q;
  logic signed [15:0]     eval_q;
  logic [7:0]             depth_q;
  logic [1:0]             flag_q;
  logic [15:0]            move_q;
  logic [GEN_W-1:0]       gen_in_q;
  logic [GEN_W-1:0]       wr_gen_q;
  status_e                status_q;
  logic signed [15:0]     found_eval_q;
  logic [7:0]             found_depth_q;
  logic [1:0]             found_flag_q;
  logic [15:0]            found_move_q;
  logic [COUNT_W-1:0]     count_q;
  logic [COUNT_W-1:0]     count_d;

  logic                   rsp_valid_q;
  status_e                rsp_status_q;
  logic signed [15:0]     rsp_eval_q;
  logic [7:0]             rsp_depth_q;
  logic [1:0]             rsp_flag_q;
  logic [15:0]            rsp_move_q;
  logic [COUNT_W-1:0]     rsp_count_q;

  way_entry_t             mem_q [Depth];
  way_entry_t             rdata_q;
  way_entry_t             wr_data;
  logic [AddrBits-1:0]    rd_addr;
  logic [AddrBits-1:0]    wr_addr;
  logic                   mem_we;
  logic                   req_fire;
  logic                   finish_fire;
  way_eval_t              ev;

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign finish_fire = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_o.ready);

  assign count_d = ((status_q == STAT_STORED) && (count_q != COUNT_MAX)) ?
                   count_q + COUNT_W'(1) : count_q;

  // Read way 0 on acceptance, then the way after the one being judged.
  always_comb begin
    if (state_q == ST_IDLE) begin
      rd_addr = {req_i.key[INDEX_BITS-1:0], WayBits'(0)};
    end else begin
      rd_addr = {cluster_q, way_q + WayBits'(1)};
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = clr_q;
    wr_data = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (finish_fire && do_write_q) begin
      mem_we        = 1'b1;
      wr_addr       = {cluster_q, wr_way_q};
      wr_data.valid = 1'b1;
      wr_data.tag   = tag_q;
      wr_data.eval  = eval_q;
      wr_data.depth = depth_q;
      wr_data.flag  = flag_q;
      wr_data.move  = move_q;
      wr_data.gen   = wr_gen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  chtd_way_eval u_eval (
    .entry_i   (rdata_q),
    .tag_i     (tag_q),
    .depth_i   (depth_q),
    .cur_gen_i (cur_gen_q),
    .eval_o    (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      cur_gen_q     <= '0;
      way_q         <= '0;
      wr_way_q      <= '0;
      cand_way_q    <= '0;
      cand_q        <= 1'b0;
      do_write_q    <= 1'b0;
      cluster_q     <= '0;
      save_q        <= 1'b0;
      tag_q         <= '0;
      eval_q        <= '0;
      depth_q       <= '0;
      flag_q        <= '0;
      move_q        <= '0;
      gen_in_q      <= '0;
      wr_gen_q      <= '0;
      status_q      <= STAT_MISS;
      found_eval_q  <= '0;
      found_depth_q <= '0;
      found_flag_q  <= '0;
      found_move_q  <= '0;
      count_q       <= '0;
      rsp_valid_q   <= 1'b0;
      rsp_status_q  <= STAT_MISS;
      rsp_eval_q    <= '0;
      rsp_depth_q   <= '0;
      rsp_flag_q    <= '0;
      rsp_move_q    <= '0;
      rsp_count_q   <= '0;
    end else begin
      if (cfg_i.valid) begin
        cur_gen_q <= cfg_i.data;
      end
      // Drop the taken word unless a new one is loaded in the same cycle.
      if (rsp_valid_q && rsp_o.ready && !finish_fire) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrBits'(1);
          if (clr_q == LastAddr) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (req_fire) begin
            cluster_q     <= req_i.key[INDEX_BITS-1:0];
            save_q        <= (req_i.command == CMD_SAVE);
            tag_q         <= req_i.key[TAG_W-1:0];
            eval_q        <= req_i.entry_eval;
            depth_q       <= req_i.entry_depth;
            flag_q        <= req_i.entry_flag;
            move_q        <= req_i.entry_move;
            gen_in_q      <= req_i.entry_generation;
            way_q         <= '0;
            cand_q        <= 1'b0;
            do_write_q    <= 1'b0;
            found_eval_q  <= '0;
            found_depth_q <= '0;
            found_flag_q  <= '0;
            found_move_q  <= '0;
            state_q       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (!save_q) begin
            if (ev.hit) begin
              status_q      <= STAT_HIT;
              found_eval_q  <= rdata_q.eval;
              found_depth_q <= rdata_q.depth;
              found_flag_q  <= rdata_q.flag;
              found_move_q  <= rdata_q.move;
              state_q       <= ST_FINISH;
            end else if (way_q == LastWay) begin
              status_q <= STAT_MISS;
              state_q  <= ST_FINISH;
            end else begin
              way_q <= way_q + WayBits'(1);
            end
          end else begin
            if (ev.empty) begin
              status_q   <= STAT_STORED;
              do_write_q <= 1'b1;
              wr_way_q   <= way_q;
              wr_gen_q   <= gen_in_q;
              state_q    <= ST_FINISH;
            end else if (way_q == LastWay) begin
              // Cluster full: replace the first victim seen, if any.
              if (cand_q || ev.old) begin
                status_q   <= STAT_REPLACED;
                do_write_q <= 1'b1;
                wr_way_q   <= cand_q ? cand_way_q : way_q;
                wr_gen_q   <= cur_gen_q;
              end else begin
                status_q <= STAT_DROPPED;
              end
              state_q <= ST_FINISH;
            end else begin
              if (ev.old && !cand_q) begin
                cand_q     <= 1'b1;
                cand_way_q <= way_q;
              end
              way_q <= way_q + WayBits'(1);
            end
          end
        end

        ST_FINISH: begin
          // Hold until the output register is free.
          if (finish_fire) begin
            count_q      <= count_d;
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= status_q;
            rsp_eval_q   <= found_eval_q;
            rsp_depth_q  <= found_depth_q;
            rsp_flag_q   <= found_flag_q;
            rsp_move_q   <= found_move_q;
            rsp_count_q  <= count_d;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_eval  = rsp_eval_q;
  assign rsp_o.found_depth = rsp_depth_q;
  assign rsp_o.found_flag  = rsp_flag_q;
  assign rsp_o.found_move  = rsp_move_q;
  assign rsp_o.entry_count = rsp_count_q;

  `ASSERT_RST(a_rsp_from_finish, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(state_q == ST_FINISH), "result word not loaded from finish state")
  `ASSERT_RST(a_count_only_on_store, clk_i, rst_ni, (count_q != $past(count_q)) |-> ((count_q == $past(count_q) + COUNT_W'(1)) && $past(finish_fire && (status_q == STAT_STORED))), "entry count moved without a store")
  `ASSERT_RST(a_save_status, clk_i, rst_ni, (finish_fire && save_q) |-> ((status_q != STAT_MISS) && (status_q != STAT_HIT)), "save finished with a lookup status")
  `ASSERT_RST(a_write_only_save, clk_i, rst_ni, (mem_we && (state_q != ST_CLEAR)) |-> (save_q && finish_fire), "table written outside a save")

endmodule

@@ rtl/core/chtd_way_eval.sv @@
// Shared compare unit: judges one way of a cluster for hit, empty and age/depth victim.
// Depends on chtd_pkg.
module chtd_way_eval (
  input  chtd_pkg::way_entry_t          entry_i,
  input  logic [chtd_pkg::TAG_W-1:0]    tag_i,
  input  logic [7:0]                    depth_i,
  input  logic [chtd_pkg::GEN_W-1:0]    cur_gen_i,
  output chtd_pkg::way_eval_t           eval_o
);
  import chtd_pkg::*;

  logic [GEN_W:0] aged_gen;

  // Generation plus margin without wrap.
  assign aged_gen = {1'b0, entry_i.gen} + (GEN_W + 1)'(AGE_MARGIN);

  assign eval_o.empty = !entry_i.valid;
  assign eval_o.hit   = entry_i.valid && (entry_i.tag == tag_i);
  assign eval_o.old   = (entry_i.depth < depth_i) || (aged_gen < {1'b0, cur_gen_i});

endmodule
